// ===== design/assert_macros.svh =====
// Assertion macros used by the top design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define AJC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ajc assertion failed");
// next-cycle implication
`define AJC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ajc assertion failed");
`else
`define AJC_ASSERT_IMPL(lbl, ante, cons)
`define AJC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/ajc_pkg.sv =====
// Types and constants for the arm Jacobian column engine.
package ajc_pkg;

  localparam int COORD_W    = 32;
  localparam int COORD_FRAC = COORD_W / 2;
  localparam int ANGLE_W    = 16;
  localparam int JOINTS     = 7;
  localparam int JOINT_W    = 3;
  localparam int LEN_W      = 31;
  localparam int TRIG_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int CHAIN_LEN  = 9;
  localparam int NEST_SLOTS = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ELBOW_WRIST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRIST_FINGER = 2'd1;

  // pi in Q2.30 and one in Q2.30
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  typedef enum logic [1:0] {OP_ROTX, OP_ROTY, OP_ROTZ, OP_SHIFT} op_kind_t;

  // transform chain, applied first to last; arg is angle number or register number
  localparam op_kind_t CHAIN_KIND [CHAIN_LEN] = '{OP_ROTX, OP_ROTY, OP_SHIFT,
                                                   OP_ROTX, OP_ROTY, OP_SHIFT,
                                                   OP_ROTX, OP_ROTY, OP_ROTZ};
  localparam int CHAIN_ARG [CHAIN_LEN] = '{5, 6, 1, 3, 4, 0, 0, 1, 2};

  // series denominators; zero marks a pass-through slot
  localparam int SIN_DEN [NEST_SLOTS] = '{156, 110, 72, 42, 20, 6, 0};
  localparam int COS_DEN [NEST_SLOTS] = '{182, 132, 90, 56, 30, 12, 2};
  localparam logic [31:0] SIN_RCP [NEST_SLOTS] = '{
    32'((64'd1 << 32) / 156), 32'((64'd1 << 32) / 110), 32'((64'd1 << 32) / 72),
    32'((64'd1 << 32) / 42),  32'((64'd1 << 32) / 20),  32'((64'd1 << 32) / 6),
    32'd0};
  localparam logic [31:0] COS_RCP [NEST_SLOTS] = '{
    32'((64'd1 << 32) / 182), 32'((64'd1 << 32) / 132), 32'((64'd1 << 32) / 90),
    32'((64'd1 << 32) / 56),  32'((64'd1 << 32) / 30),  32'((64'd1 << 32) / 12),
    32'((64'd1 << 32) / 2)};

  typedef struct packed {
    logic signed [COORD_W-1:0] pt_x;
    logic signed [COORD_W-1:0] pt_y;
    logic signed [COORD_W-1:0] pt_z;
    logic signed [COORD_W-1:0] pt_w;
    logic [ANGLE_W-1:0]        ang_one;
    logic [ANGLE_W-1:0]        ang_two;
    logic [ANGLE_W-1:0]        ang_three;
    logic [ANGLE_W-1:0]        ang_four;
    logic [ANGLE_W-1:0]        ang_five;
    logic [ANGLE_W-1:0]        ang_six;
    logic [ANGLE_W-1:0]        ang_seven;
  } ajc_in_t;

  typedef struct packed {
    logic [JOINT_W-1:0]        joint_index;
    logic signed [COORD_W-1:0] col_x;
    logic signed [COORD_W-1:0] col_y;
    logic signed [COORD_W-1:0] col_z;
    logic                      last_col;
  } ajc_out_t;

  // plane of a rotation: first, second and untouched coordinate
  function automatic int plane_p(input op_kind_t k);
    case (k)
      OP_ROTX: return 1;
      OP_ROTY: return 2;
      default: return 0;
    endcase
  endfunction

  function automatic int plane_q(input op_kind_t k);
    case (k)
      OP_ROTX: return 2;
      OP_ROTY: return 0;
      default: return 1;
    endcase
  endfunction

  function automatic int plane_o(input op_kind_t k);
    case (k)
      OP_ROTX: return 0;
      OP_ROTY: return 1;
      default: return 2;
    endcase
  endfunction

endpackage

// ===== design/arm_jacobian_columns_top.sv =====
// Arm position Jacobian engine: one input word in, seven column words out.
//
// A word is taken when start is high and busy low; busy then stays high while
// its angles are fed out and drops as the last angle is fed, so the next word
// can be taken with the last angle. The seven angles go one per cycle through a
// pipelined sine/cosine series unit (26 stages), then the columns enter an
// 18-stage transform chain one per cycle. Column 0 appears on result first and
// the other six follow back to back, the seventh with last_col set.
// strobe marks each result for one cycle; the receiver cannot stall, so
// results must be taken when shown. Configuration writes are always ready.
`include "assert_macros.svh"

module arm_jacobian_columns_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  ajc_pkg::ajc_in_t                 item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ajc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ajc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             strobe,
  output ajc_pkg::ajc_out_t                result
);
  import ajc_pkg::*;

  localparam int TS   = 5 + 3 * NEST_SLOTS;   // trig pipeline stages
  localparam int AH_W = COORD_W - 16;         // high part of a split coordinate
  localparam int PW   = COORD_W + 34;         // product sum width
  localparam logic signed [PW-1:0] CMAX =
    $signed({{(PW-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}});
  localparam logic signed [PW-1:0] CMIN = -CMAX - 1;

  typedef struct packed {
    logic [JOINT_W-1:0]             idx;
    logic                           last;
    logic [1:0]                     quad;
    logic [30:0]                    x;
    logic [31:0]                    x2;
    logic [3:0][COORD_W-1:0]        pt;
  } trig_tag_t;

  typedef struct packed {
    logic [JOINT_W-1:0]             joint;
    logic                           last;
    logic [3:0][COORD_W-1:0]        v;
    logic [JOINTS-1:0][TRIG_W-1:0]  s;
    logic [JOINTS-1:0][TRIG_W-1:0]  c;
  } col_t;

  // arithmetic helpers
  function automatic logic signed [AH_W-1:0] hi_of(input logic signed [COORD_W-1:0] a);
    logic signed [COORD_W-1:0] sh;
    sh = a >>> 16;
    return sh[AH_W-1:0];
  endfunction

  function automatic logic signed [PW-1:0] fl_sum(input logic signed [AH_W+31:0] hi,
                                                  input logic signed [48:0] lo,
                                                  input int sh);
    logic signed [PW-1:0] sum;
    sum = (PW'(hi) <<< 16) + PW'(lo);
    return sum >>> sh;
  endfunction

  function automatic logic [COORD_W-1:0] sat(input logic signed [PW-1:0] v);
    if (v > CMAX) return CMAX[COORD_W-1:0];
    if (v < CMIN) return CMIN[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

  // configuration registers
  logic [LEN_W-1:0] elbow_len;
  logic [LEN_W-1:0] wrist_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      elbow_len <= '0;
      wrist_len <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ELBOW_WRIST:  elbow_len <= cfg_data[LEN_W-1:0];
        REG_WRIST_FINGER: wrist_len <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture and angle feed, one angle per cycle
  logic                    feed_act;
  logic [JOINT_W-1:0]      feed_cnt;
  logic [ANGLE_W-1:0]      ang_reg [JOINTS];
  logic [3:0][COORD_W-1:0] pt_reg;
  logic                    accept;
  logic [ANGLE_W-1:0]      cur_ang;

  assign busy    = feed_act && (feed_cnt != JOINT_W'(JOINTS - 1));
  assign accept  = start && !busy;
  assign cur_ang = ang_reg[feed_cnt];

  always_ff @(posedge clk) begin
    if (rst) begin
      feed_act <= 1'b0;
      feed_cnt <= '0;
    end else if (accept) begin
      feed_act <= 1'b1;
      feed_cnt <= '0;
    end else if (feed_act) begin
      if (feed_cnt == JOINT_W'(JOINTS - 1)) feed_act <= 1'b0;
      feed_cnt <= feed_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pt_reg[0]  <= item.pt_x;
      pt_reg[1]  <= item.pt_y;
      pt_reg[2]  <= item.pt_z;
      pt_reg[3]  <= item.pt_w;
      ang_reg[0] <= item.ang_one;
      ang_reg[1] <= item.ang_two;
      ang_reg[2] <= item.ang_three;
      ang_reg[3] <= item.ang_four;
      ang_reg[4] <= item.ang_five;
      ang_reg[5] <= item.ang_six;
      ang_reg[6] <= item.ang_seven;
    end
  end

  // trig front: angle to radians, then square
  logic                    tg_vld [TS];
  trig_tag_t               tg     [TS];
  trig_tag_t               tg1_in;
  trig_tag_t               tg2_in;
  logic [ANGLE_W+29:0]     f0_prod;
  logic [61:0]             f1_xx;
  logic [30:0]             x0;

  assign x0 = f0_prod[ANGLE_W-1 +: 31];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < TS; n++) tg_vld[n] <= 1'b0;
    end else begin
      tg_vld[0] <= feed_act;
      for (int n = 1; n < TS; n++) tg_vld[n] <= tg_vld[n-1];
    end
  end

  // radians and square join the tag at stages 1 and 2
  always_comb begin
    tg1_in    = tg[0];
    tg1_in.x  = x0;
    tg2_in    = tg[1];
    tg2_in.x2 = f1_xx[61:30];
  end

  always_ff @(posedge clk) begin
    tg[0].idx  <= feed_cnt;
    tg[0].last <= (feed_cnt == JOINT_W'(JOINTS - 1));
    tg[0].quad <= cur_ang[ANGLE_W-1:ANGLE_W-2];
    tg[0].x    <= '0;
    tg[0].x2   <= '0;
    tg[0].pt   <= pt_reg;
    f0_prod    <= cur_ang[ANGLE_W-3:0] * PI_Q30;
    f1_xx      <= 62'(x0) * 62'(x0);
    tg[1]      <= tg1_in;
    tg[2]      <= tg2_in;
    for (int n = 3; n < TS; n++) tg[n] <= tg[n-1];
  end

  // series nest: lane 0 sine, lane 1 cosine; three stages per slot
  logic signed [64:0] na_p   [2][NEST_SLOTS];
  logic signed [31:0] na_t   [2][NEST_SLOTS];
  logic [63:0]        nb_p   [2][NEST_SLOTS];
  logic [31:0]        nb_mag [2][NEST_SLOTS];
  logic               nb_neg [2][NEST_SLOTS];
  logic signed [31:0] nb_t   [2][NEST_SLOTS];
  logic signed [31:0] nc_t   [2][NEST_SLOTS];
  logic signed [31:0] n_tin  [2][NEST_SLOTS];
  logic [31:0]        n_mag  [2][NEST_SLOTS];
  logic               n_neg  [2][NEST_SLOTS];
  logic [31:0]        n_rcp  [2][NEST_SLOTS];
  logic signed [31:0] n_tnew [2][NEST_SLOTS];

  always_comb begin
    logic signed [34:0] qv;
    logic [34:0]        qabs;
    logic [31:0]        qa;
    logic [39:0]        qk;
    logic [39:0]        rem;
    logic [32:0]        quo;
    logic signed [33:0] qd;
    logic signed [33:0] tn;
    int                 kd;
    for (int l = 0; l < 2; l++) begin
      for (int i = 0; i < NEST_SLOTS; i++) begin
        kd = (l == 0) ? SIN_DEN[i] : COS_DEN[i];
        n_rcp[l][i] = (l == 0) ? SIN_RCP[i] : COS_RCP[i];
        n_tin[l][i] = (i == 0) ? ONE_Q30 : nc_t[l][i-1];
        // floor by 2^30, then magnitude for the truncating divide
        qv = na_p[l][i][64:30];
        n_neg[l][i] = qv[34];
        qabs = qv[34] ? 35'(-qv) : 35'(qv);
        n_mag[l][i] = qabs[31:0];
        // reciprocal quotient, one correction step
        qa  = nb_p[l][i][63:32];
        qk  = 40'(qa) * 40'(kd);
        rem = {8'd0, nb_mag[l][i]} - qk;
        quo = 33'(qa) + 33'(rem >= 40'(kd));
        qd  = nb_neg[l][i] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        tn  = 34'(ONE_Q30) - qd;
        n_tnew[l][i] = (kd == 0) ? nb_t[l][i] : tn[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      for (int i = 0; i < NEST_SLOTS; i++) begin
        na_p[l][i]   <= $signed({1'b0, tg[2+3*i].x2}) * n_tin[l][i];
        na_t[l][i]   <= n_tin[l][i];
        nb_p[l][i]   <= 64'(n_mag[l][i]) * 64'(n_rcp[l][i]);
        nb_mag[l][i] <= n_mag[l][i];
        nb_neg[l][i] <= n_neg[l][i];
        nb_t[l][i]   <= na_t[l][i];
        nc_t[l][i]   <= n_tnew[l][i];
      end
    end
  end

  // sine product and quadrant fold
  logic signed [63:0] fm_p;
  logic signed [31:0] fm_c;
  logic signed [31:0] fm_s;
  logic signed [31:0] ts_s;
  logic signed [31:0] ts_c;

  assign fm_s = fm_p[61:30];

  always_ff @(posedge clk) begin
    fm_p <= $signed({1'b0, tg[TS-3].x}) * nc_t[0][NEST_SLOTS-1];
    fm_c <= nc_t[1][NEST_SLOTS-1];
    case (tg[TS-2].quad)
      2'd0: begin
        ts_s <= fm_s;
        ts_c <= fm_c;
      end
      2'd1: begin
        ts_s <= fm_c;
        ts_c <= -fm_s;
      end
      2'd2: begin
        ts_s <= -fm_s;
        ts_c <= -fm_c;
      end
      default: begin
        ts_s <= -fm_c;
        ts_c <= fm_s;
      end
    endcase
  end

  // collect the seven pairs, hand a full set to the column issue bank
  logic [JOINTS-1:0][TRIG_W-1:0] tb_s;
  logic [JOINTS-1:0][TRIG_W-1:0] tb_c;
  logic [JOINTS-1:0][TRIG_W-1:0] bank_s;
  logic [JOINTS-1:0][TRIG_W-1:0] bank_c;
  logic [3:0][COORD_W-1:0]       bank_pt;
  logic                          iss_act;
  logic [JOINT_W-1:0]            iss_cnt;
  logic                          set_done;

  assign set_done = tg_vld[TS-1] && tg[TS-1].last;

  always_ff @(posedge clk) begin
    if (tg_vld[TS-1]) begin
      tb_s[tg[TS-1].idx] <= ts_s;
      tb_c[tg[TS-1].idx] <= ts_c;
    end
    if (set_done) begin
      for (int j = 0; j < JOINTS - 1; j++) begin
        bank_s[j] <= tb_s[j];
        bank_c[j] <= tb_c[j];
      end
      bank_s[JOINTS-1] <= ts_s;
      bank_c[JOINTS-1] <= ts_c;
      bank_pt <= tg[TS-1].pt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_act <= 1'b0;
      iss_cnt <= '0;
    end else if (set_done) begin
      iss_act <= 1'b1;
      iss_cnt <= '0;
    end else if (iss_act) begin
      if (iss_cnt == JOINT_W'(JOINTS - 1)) iss_act <= 1'b0;
      iss_cnt <= iss_cnt + 1'b1;
    end
  end

  // transform chain: multiply stage then sum/saturate stage per op
  logic                      c_vld [CHAIN_LEN+1];
  col_t                      cs    [CHAIN_LEN+1];
  col_t                      cs_next [CHAIN_LEN+1];
  logic                      m_vld [CHAIN_LEN];
  logic                      m_der [CHAIN_LEN];
  col_t                      cm    [CHAIN_LEN];
  logic signed [AH_W+31:0]   ph    [CHAIN_LEN][4];
  logic signed [48:0]        pl    [CHAIN_LEN][4];
  logic signed [COORD_W-1:0] op_a  [CHAIN_LEN][4];
  logic signed [31:0]        op_b  [CHAIN_LEN][4];
  logic                      op_der [CHAIN_LEN];

  // operand selection; the differentiated joint uses (c, -s)
  always_comb begin
    logic signed [31:0]        sr;
    logic signed [31:0]        cr;
    logic signed [31:0]        se;
    logic signed [31:0]        ce;
    logic signed [COORD_W-1:0] pv;
    logic signed [COORD_W-1:0] qv;
    logic [LEN_W-1:0]          len;
    for (int k = 0; k < CHAIN_LEN; k++) begin
      if (CHAIN_KIND[k] == OP_SHIFT) begin
        len = (CHAIN_ARG[k] == 0) ? elbow_len : wrist_len;
        op_der[k]  = 1'b0;
        op_a[k][0] = $signed(cs[k].v[3]);
        op_b[k][0] = $signed({1'b0, len});
        for (int n = 1; n < 4; n++) begin
          op_a[k][n] = '0;
          op_b[k][n] = '0;
        end
      end else begin
        sr = $signed(cs[k].s[CHAIN_ARG[k]]);
        cr = $signed(cs[k].c[CHAIN_ARG[k]]);
        op_der[k] = (cs[k].joint == JOINT_W'(CHAIN_ARG[k]));
        se = op_der[k] ? cr : sr;
        ce = op_der[k] ? -sr : cr;
        pv = $signed(cs[k].v[plane_p(CHAIN_KIND[k])]);
        qv = $signed(cs[k].v[plane_q(CHAIN_KIND[k])]);
        op_a[k][0] = pv;
        op_b[k][0] = ce;
        op_a[k][1] = qv;
        op_b[k][1] = se;
        op_a[k][2] = pv;
        op_b[k][2] = se;
        op_a[k][3] = qv;
        op_b[k][3] = ce;
      end
    end
  end

  // sums of floored products, saturated
  always_comb begin
    logic signed [PW-1:0] f [4];
    int                   sh;
    cs_next[0] = cs[0];
    for (int k = 0; k < CHAIN_LEN; k++) begin
      sh = (CHAIN_KIND[k] == OP_SHIFT) ? COORD_FRAC : 30;
      for (int n = 0; n < 4; n++) f[n] = fl_sum(ph[k][n], pl[k][n], sh);
      cs_next[k+1] = cm[k];
      if (CHAIN_KIND[k] == OP_SHIFT) begin
        cs_next[k+1].v[1] = sat(PW'($signed(cm[k].v[1])) - f[0]);
      end else begin
        cs_next[k+1].v[plane_p(CHAIN_KIND[k])] = sat(f[0] - f[1]);
        cs_next[k+1].v[plane_q(CHAIN_KIND[k])] = sat(f[2] + f[3]);
        if (m_der[k]) begin
          cs_next[k+1].v[plane_o(CHAIN_KIND[k])] = '0;
          cs_next[k+1].v[3] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= CHAIN_LEN; k++) c_vld[k] <= 1'b0;
      for (int k = 0; k < CHAIN_LEN; k++) m_vld[k] <= 1'b0;
    end else begin
      c_vld[0] <= iss_act;
      for (int k = 0; k < CHAIN_LEN; k++) begin
        m_vld[k]   <= c_vld[k];
        c_vld[k+1] <= m_vld[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    cs[0].joint <= iss_cnt;
    cs[0].last  <= (iss_cnt == JOINT_W'(JOINTS - 1));
    cs[0].v     <= bank_pt;
    cs[0].s     <= bank_s;
    cs[0].c     <= bank_c;
    for (int k = 0; k < CHAIN_LEN; k++) begin
      cm[k]    <= cs[k];
      m_der[k] <= op_der[k];
      for (int n = 0; n < 4; n++) begin
        ph[k][n] <= hi_of(op_a[k][n]) * op_b[k][n];
        pl[k][n] <= $signed({1'b0, op_a[k][n][15:0]}) * op_b[k][n];
      end
      cs[k+1] <= cs_next[k+1];
    end
  end

  // result word
  assign strobe             = c_vld[CHAIN_LEN];
  assign result.joint_index = cs[CHAIN_LEN].joint;
  assign result.col_x       = $signed(cs[CHAIN_LEN].v[0]);
  assign result.col_y       = $signed(cs[CHAIN_LEN].v[1]);
  assign result.col_z       = $signed(cs[CHAIN_LEN].v[2]);
  assign result.last_col    = cs[CHAIN_LEN].last;

  // checks
  `AJC_ASSERT_NEXT(a_start_sets_busy, start && !busy, busy)
  `AJC_ASSERT_IMPL(a_last_is_final_joint, strobe && result.last_col, result.joint_index == JOINT_W'(JOINTS - 1))
  `AJC_ASSERT_NEXT(a_columns_contiguous, strobe && !result.last_col, strobe)
  `AJC_ASSERT_IMPL(a_bank_free_on_set, set_done, !iss_act || iss_cnt == JOINT_W'(JOINTS - 1))

endmodule
